// ----- hdl/multitouch_slot_tracker_unit_defines.svh -----
// Assertion macros shared by the slot tracker RTL.
`ifndef MULTITOUCH_SLOT_TRACKER_UNIT_DEFINES_SVH
`define MULTITOUCH_SLOT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define MSTU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mstu: assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define MSTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mstu: assertion failed");

`endif

// ----- hdl/mstu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, event codes and sizing constants for the slot tracker.
package mstu_pkg;

   localparam int MAX_SLOTS   = 16;
   localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Event types and codes.
   localparam logic [4:0] TYPE_SYN    = 5'd0;
   localparam logic [4:0] TYPE_ABS    = 5'd3;
   localparam logic [9:0] CODE_REPORT = 10'h000;
   localparam logic [9:0] CODE_SLOT   = 10'h02f;
   localparam logic [9:0] CODE_TRACK  = 10'h039;
   localparam logic [9:0] CODE_POS_X  = 10'h035;
   localparam logic [9:0] CODE_POS_Y  = 10'h036;

   localparam logic [31:0] NO_CONTACT    = 32'hFFFF_FFFF;
   localparam logic [4:0]  DEFAULT_SLOTS = 5'd10;

   // Result kinds.
   localparam logic [1:0] KIND_DOWN  = 2'd0;
   localparam logic [1:0] KIND_UP    = 2'd1;
   localparam logic [1:0] KIND_MOVE  = 2'd2;
   localparam logic [1:0] KIND_FRAME = 2'd3;

   // Commands passed from the front end to the back end.
   localparam logic [1:0] OP_TRACK  = 2'd0;
   localparam logic [1:0] OP_POS_X  = 2'd1;
   localparam logic [1:0] OP_POS_Y  = 2'd2;
   localparam logic [1:0] OP_REPORT = 2'd3;

   typedef struct packed {
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         slot_index;
      logic signed [31:0] track_id;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [4:0]         active_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       value;
      logic [CNT_W-1:0]  slots;
   } cmd_type;

endpackage

// ----- hdl/mstu_front.sv -----
`timescale 1ns / 1ps
// Front end: slot count register, slot selection and event classification.
module mstu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata,
   input  logic              accept_i,
   input  mstu_pkg::req_type req_i,
   output logic              push_o,
   output mstu_pkg::cmd_type cmd_o
);

   logic [4:0]  slot_count_ff;
   logic [31:0] sel_ff;
   logic [31:0] sel_in;
   logic [31:0] live_n;
   logic        in_range;

   // Effective slot count: zero means the default, and the count is capped.
   always_comb begin
      if (slot_count_ff == 5'd0) begin
         live_n = 32'(mstu_pkg::DEFAULT_SLOTS);
      end else begin
         live_n = 32'(slot_count_ff);
      end
      if (live_n > 32'(mstu_pkg::MAX_SLOTS)) begin
         live_n = 32'(mstu_pkg::MAX_SLOTS);
      end
   end

   assign in_range = (sel_ff < live_n);

   always_comb begin
      sel_in      = sel_ff;
      push_o      = 1'b0;
      cmd_o.op    = mstu_pkg::OP_REPORT;
      cmd_o.slot  = mstu_pkg::SLOT_W'(sel_ff);
      cmd_o.value = req_i.ev_value;
      cmd_o.slots = mstu_pkg::CNT_W'(live_n);
      if (accept_i) begin
         if (req_i.ev_type == mstu_pkg::TYPE_ABS) begin
            unique case (req_i.ev_code)
               mstu_pkg::CODE_SLOT: begin
                  sel_in = req_i.ev_value;
               end
               mstu_pkg::CODE_TRACK: begin
                  push_o   = in_range;
                  cmd_o.op = mstu_pkg::OP_TRACK;
               end
               mstu_pkg::CODE_POS_X: begin
                  push_o   = in_range;
                  cmd_o.op = mstu_pkg::OP_POS_X;
               end
               mstu_pkg::CODE_POS_Y: begin
                  push_o   = in_range;
                  cmd_o.op = mstu_pkg::OP_POS_Y;
               end
               default: begin
               end
            endcase
         end else if (req_i.ev_type == mstu_pkg::TYPE_SYN &&
                      req_i.ev_code == mstu_pkg::CODE_REPORT) begin
            push_o   = 1'b1;
            cmd_o.op = mstu_pkg::OP_REPORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= mstu_pkg::DEFAULT_SLOTS;
         sel_ff        <= '0;
      end else begin
         if (csr_we) begin
            slot_count_ff <= csr_wdata;
         end
         sel_ff <= sel_in;
      end
   end

endmodule

// ----- hdl/mstu_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
`include "multitouch_slot_tracker_unit_defines.svh"
module mstu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  mstu_pkg::cmd_type cmd_i,
   input  logic              pop_i,
   output logic              valid_o,
   output logic              full_o,
   output mstu_pkg::cmd_type head_o
);

   mstu_pkg::cmd_type                 mem_ff [mstu_pkg::QUEUE_DEPTH];
   logic [mstu_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [mstu_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [mstu_pkg::QCNT_W-1:0]       count_ff;
   logic [mstu_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [mstu_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [mstu_pkg::QCNT_W-1:0]       count_in;

   assign valid_o = (count_ff != '0);
   assign full_o  = (count_ff == mstu_pkg::QCNT_W'(mstu_pkg::QUEUE_DEPTH));
   assign head_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         if (wr_ptr_ff == mstu_pkg::QPTR_W'(mstu_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + mstu_pkg::QPTR_W'(1);
         end
      end
      if (pop_i) begin
         if (rd_ptr_ff == mstu_pkg::QPTR_W'(mstu_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + mstu_pkg::QPTR_W'(1);
         end
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + mstu_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - mstu_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= cmd_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MSTU_ASSERT_NOW(a_no_push_when_full, clock, reset, push_i, !full_o)
   `MSTU_ASSERT_NOW(a_no_pop_when_empty, clock, reset, pop_i, valid_o)
   `MSTU_ASSERT_NEXT(a_push_only_grows, clock, reset, push_i && !pop_i,
                     count_ff == $past(count_ff) + mstu_pkg::QCNT_W'(1))

endmodule

// ----- hdl/mstu_back.sv -----
`timescale 1ns / 1ps
// Back end: per-slot contact state, command execution and the report scan.
`include "multitouch_slot_tracker_unit_defines.svh"
module mstu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid_i,
   input  mstu_pkg::cmd_type head_i,
   output logic              pop_o,
   output logic              rsp_valid_o,
   output mstu_pkg::rsp_type rsp_o
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FRAME = 2'd2;

   logic [1:0]                     state_ff;
   logic [1:0]                     state_in;
   logic [mstu_pkg::SLOT_W-1:0]    idx_ff;
   logic [mstu_pkg::SLOT_W-1:0]    idx_in;
   logic [mstu_pkg::CNT_W-1:0]     cnt_ff;
   logic [mstu_pkg::CNT_W-1:0]     cnt_in;
   logic [mstu_pkg::CNT_W-1:0]     n_ff;
   logic [mstu_pkg::CNT_W-1:0]     n_in;
   logic                           any_ff;
   logic                           any_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   mstu_pkg::rsp_type              rsp_ff;
   mstu_pkg::rsp_type              rsp_in;

   logic [31:0]                    id_ff   [mstu_pkg::MAX_SLOTS];
   logic [31:0]                    x_ff    [mstu_pkg::MAX_SLOTS];
   logic [31:0]                    y_ff    [mstu_pkg::MAX_SLOTS];
   logic [mstu_pkg::MAX_SLOTS-1:0] mark_ff;

   logic [mstu_pkg::SLOT_W-1:0]    addr;
   logic [31:0]                    rd_id;
   logic                           rd_mark;
   logic                           live;
   logic                           last_idx;
   logic                           emit_move;
   logic                           id_we;
   logic [31:0]                    id_wdata;
   logic                           x_we;
   logic                           y_we;
   logic                           mark_set;
   logic                           mark_clr;

   // One slot is looked at per cycle: the commanded slot or the scan slot.
   assign addr      = (state_ff == ST_SCAN) ? idx_ff : head_i.slot;
   assign rd_id     = id_ff[addr];
   assign rd_mark   = mark_ff[addr];
   assign live      = (rd_id != mstu_pkg::NO_CONTACT);
   assign last_idx  = ((mstu_pkg::CNT_W'(idx_ff) + mstu_pkg::CNT_W'(1)) == n_ff);
   assign emit_move = (state_ff == ST_SCAN) && rd_mark && live;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      any_in       = any_ff;
      pop_o        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      id_we        = 1'b0;
      id_wdata     = head_i.value;
      x_we         = 1'b0;
      y_we         = 1'b0;
      mark_set     = 1'b0;
      mark_clr     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid_i) begin
               pop_o = 1'b1;
               unique case (head_i.op)
                  mstu_pkg::OP_TRACK: begin
                     id_we             = 1'b1;
                     rsp_valid_in      = 1'b1;
                     rsp_in.slot_index = 4'(head_i.slot);
                     rsp_in.last       = 1'b1;
                     if (head_i.value == mstu_pkg::NO_CONTACT) begin
                        // A lift reports the id that was there, even when idle.
                        rsp_in.kind     = mstu_pkg::KIND_UP;
                        rsp_in.track_id = rd_id;
                        id_wdata        = mstu_pkg::NO_CONTACT;
                     end else begin
                        rsp_in.kind     = mstu_pkg::KIND_DOWN;
                        rsp_in.track_id = head_i.value;
                     end
                  end
                  mstu_pkg::OP_POS_X: begin
                     x_we     = 1'b1;
                     mark_set = 1'b1;
                  end
                  mstu_pkg::OP_POS_Y: begin
                     y_we     = 1'b1;
                     mark_set = 1'b1;
                  end
                  mstu_pkg::OP_REPORT: begin
                     state_in = ST_SCAN;
                     idx_in   = '0;
                     cnt_in   = '0;
                     any_in   = 1'b0;
                     n_in     = head_i.slots;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (emit_move) begin
               mark_clr          = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_in.kind       = mstu_pkg::KIND_MOVE;
               rsp_in.slot_index = 4'(idx_ff);
               rsp_in.track_id   = rd_id;
               rsp_in.pos_x      = x_ff[addr];
               rsp_in.pos_y      = y_ff[addr];
            end
            cnt_in = cnt_ff + mstu_pkg::CNT_W'(live);
            any_in = any_ff | emit_move;
            if (last_idx) begin
               state_in = (any_ff || emit_move) ? ST_FRAME : ST_IDLE;
            end else begin
               idx_in = idx_ff + mstu_pkg::SLOT_W'(1);
            end
         end
         ST_FRAME: begin
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = mstu_pkg::KIND_FRAME;
            rsp_in.active_count = 5'(cnt_ff);
            rsp_in.last         = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mstu_pkg::MAX_SLOTS; i++) begin
            id_ff[i] <= mstu_pkg::NO_CONTACT;
            x_ff[i]  <= '0;
            y_ff[i]  <= '0;
         end
         mark_ff <= '0;
      end else begin
         if (id_we) begin
            id_ff[addr] <= id_wdata;
         end
         if (x_we) begin
            x_ff[addr] <= head_i.value;
         end
         if (y_we) begin
            y_ff[addr] <= head_i.value;
         end
         if (mark_set) begin
            mark_ff[addr] <= 1'b1;
         end else if (mark_clr) begin
            mark_ff[addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

   `MSTU_ASSERT_NOW(a_frame_needs_move, clock, reset, state_ff == ST_FRAME, any_ff)
   `MSTU_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
                    mstu_pkg::CNT_W'(idx_ff) < n_ff)
   `MSTU_ASSERT_NEXT(a_report_starts_scan, clock, reset,
                     pop_o && head_i.op == mstu_pkg::OP_REPORT, state_ff == ST_SCAN)

endmodule

// ----- hdl/multitouch_slot_tracker_unit.sv -----
`timescale 1ns / 1ps
// Top level of the multi-touch protocol B slot tracker.
// A tracking-id event passes through the command queue, the back end and its result
//   register; report moves come out in slot order as the scan reaches each slot.
// The back end takes one queued command at a time; a report runs through the pop, a
//   scan over the effective slot count and a frame end, the last only when a slot moved.
// Reset (synchronous): slot count 10, slot 0 selected, all contacts idle, marks clear.
module multitouch_slot_tracker_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mstu_pkg::req_type req_data,
   output logic              rsp_valid,
   output mstu_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);

   logic              accept;
   logic              push;
   logic              pop;
   logic              q_valid;
   logic              q_full;
   mstu_pkg::cmd_type push_cmd;
   mstu_pkg::cmd_type head_cmd;

   // An event transfer happens whenever start is high and the queue has room.
   // Busy is driven only by a full queue, so events keep flowing during scans.
   assign busy   = q_full;
   assign accept = start && !busy;

   // The front end owns the slot count register and the selected slot. It
   // drops events that produce nothing (slot selects, out-of-range slots,
   // unknown codes) and hands the rest to the queue as compact commands.
   mstu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept_i  (accept),
      .req_i     (req_data),
      .push_o    (push),
      .cmd_o     (push_cmd)
   );

   // The four-entry queue decouples classification from execution, so a long
   // report scan in the back end does not stall the event stream right away.
   mstu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .cmd_i   (push_cmd),
      .pop_i   (pop),
      .valid_o (q_valid),
      .full_o  (q_full),
      .head_o  (head_cmd)
   );

   // The back end holds per-slot contact state, executes one command at a
   // time, walks the slots one per cycle on a report and drives the
   // registered result strobe. The receiver cannot stall results.
   mstu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid_i   (q_valid),
      .head_i      (head_cmd),
      .pop_o       (pop),
      .rsp_valid_o (rsp_valid),
      .rsp_o       (rsp_data)
   );

endmodule

// ----- tb/multitouch_slot_tracker_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the slot tracker: tracks slot state, predicts results and compares them.
module multitouch_slot_tracker_unit_checker
   import mstu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   input  logic    csr_we,
   input  logic [4:0] csr_wdata,
   output int      error_count,
   output int      outstanding
);

   logic [4:0]  slot_count_reg;
   logic [31:0] selected_slot;
   logic [31:0] contact_id [MAX_SLOTS];
   logic [31:0] contact_x [MAX_SLOTS];
   logic [31:0] contact_y [MAX_SLOTS];
   bit          moved [MAX_SLOTS];

   rsp_type touch_results_due[$];
   rsp_type oldest;
   int      mismatches = 0;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   task automatic clear_slots();
      slot_count_reg = DEFAULT_SLOTS;
      selected_slot = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         contact_id[i] = NO_CONTACT;
         contact_x[i] = '0;
         contact_y[i] = '0;
         moved[i] = 1'b0;
      end
      touch_results_due.delete();
   endtask

   // Works out the results of one event and updates the slot state.
   task automatic track_touch_event(input req_type ev);
      logic [31:0] val;
      logic [31:0] sel;
      int unsigned n;
      int unsigned active;
      bit          any_move;
      rsp_type     r;
      val = ev.ev_value;
      sel = selected_slot;
      n = 32'(slot_count_reg);
      if (n == 0) n = 32'(DEFAULT_SLOTS);
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      any_move = 1'b0;
      active = 0;
      if (ev.ev_type == TYPE_ABS) begin
         if (ev.ev_code == CODE_SLOT) begin
            selected_slot = val;
         end else if (sel < n) begin
            case (ev.ev_code)
               CODE_TRACK: begin
                  r = '0;
                  r.slot_index = sel[3:0];
                  r.last = 1'b1;
                  if (val == NO_CONTACT) begin
                     r.kind = KIND_UP;
                     r.track_id = contact_id[sel[3:0]];
                     contact_id[sel[3:0]] = NO_CONTACT;
                  end else begin
                     r.kind = KIND_DOWN;
                     r.track_id = val;
                     contact_id[sel[3:0]] = val;
                  end
                  touch_results_due.push_back(r);
               end
               CODE_POS_X: begin
                  contact_x[sel[3:0]] = val;
                  moved[sel[3:0]] = 1'b1;
               end
               CODE_POS_Y: begin
                  contact_y[sel[3:0]] = val;
                  moved[sel[3:0]] = 1'b1;
               end
               default: ;
            endcase
         end
      end else if (ev.ev_type == TYPE_SYN && ev.ev_code == CODE_REPORT) begin
         for (int s = 0; s < n; s++) begin
            if (moved[s] && contact_id[s] != NO_CONTACT) begin
               r = '0;
               r.kind = KIND_MOVE;
               r.slot_index = s[3:0];
               r.track_id = contact_id[s];
               r.pos_x = contact_x[s];
               r.pos_y = contact_y[s];
               touch_results_due.push_back(r);
               moved[s] = 1'b0;
               any_move = 1'b1;
            end
         end
         if (any_move) begin
            for (int s = 0; s < n; s++)
               if (contact_id[s] != NO_CONTACT) active++;
            r = '0;
            r.kind = KIND_FRAME;
            r.active_count = active[4:0];
            r.last = 1'b1;
            touch_results_due.push_back(r);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%h, actual 0x%h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_slots();
      end else begin
         // A result always stems from an earlier transfer, so compare before predicting.
         if (rsp_valid) begin
            if (touch_results_due.size() == 0) begin
               $error("result with no expectation pending: kind %0d slot %0d",
                      rsp_data.kind, rsp_data.slot_index);
               mismatches++;
            end else begin
               oldest = touch_results_due.pop_front();
               check_field("kind", 32'(oldest.kind), 32'(rsp_data.kind));
               check_field("slot_index", 32'(oldest.slot_index),
                           32'(rsp_data.slot_index));
               check_field("track_id", oldest.track_id, rsp_data.track_id);
               check_field("pos_x", oldest.pos_x, rsp_data.pos_x);
               check_field("pos_y", oldest.pos_y, rsp_data.pos_y);
               check_field("active_count", 32'(oldest.active_count),
                           32'(rsp_data.active_count));
               check_field("last", 32'(oldest.last), 32'(rsp_data.last));
            end
         end
         if (csr_we) slot_count_reg = csr_wdata;
         if (start && !busy) track_touch_event(req_data);
      end
      outstanding <= touch_results_due.size();
      error_count <= mismatches;
   end

endmodule

// ----- tb/multitouch_slot_tracker_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives event streams into the slot tracker and reports the verdict.
module multitouch_slot_tracker_unit_tb;
   import mstu_pkg::*;

   // The run is bounded well above the slowest legal run: every report scans up to
   // sixteen slots, every event may wait out a sender gap, and each phase change
   // waits out the command queue.
   localparam int CYCLE_LIMIT = 200000;
   // Enough cycles to drain four queued reports that cause no result.
   localparam int DRAIN_CYCLES = 100;
   localparam int EVENTS_PER_PHASE = 62;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [4:0] csr_wdata = '0;

   int error_count;
   int outstanding;
   int cycle_count = 0;
   int burst_left = 0;
   int frame_events = 0;

   // The clock runs with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   multitouch_slot_tracker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   multitouch_slot_tracker_unit_checker slot_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Presents one event and holds it until a transfer happens. The sender works in
   // bursts: when a burst runs out, start drops for a random gap and a new burst of
   // random length begins. Long bursts give stretches with no idling at all. Start
   // is left high after a transfer so back-to-back events keep it high without
   // lowering and raising it within one time step.
   task automatic send_event(input logic [4:0] ev_type, input logic [9:0] ev_code,
                             input logic [31:0] ev_value);
      req_type ev;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      ev.ev_type = ev_type;
      ev.ev_code = ev_code;
      ev.ev_value = ev_value;
      req_data <= ev;
      start <= 1'b1;
      // Busy is read right after the edge, before the block's own updates land, so
      // it shows the value that decided the transfer at this edge.
      do @(posedge clock); while (busy);
   endtask

   // Random event that the decoder mostly ignores; it also toggles every input bit.
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)),
                       $urandom());
         1: send_event(TYPE_ABS, 10'($urandom_range(0, 1023)), $urandom());
         default: send_event(TYPE_SYN, 10'($urandom_range(1, 1023)), $urandom());
      endcase
   endtask

   // Stops sending and waits until every expected result has arrived, then lets the
   // command queue drain, since queued position events and empty reports cause no
   // result but may still be in flight.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [4:0] value);
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One protocol B frame: for each touched slot a slot select, then optionally a
   // tracking id and the coordinates, closed by a report. A full frame puts a
   // contact on every slot in order, which makes the report emit its maximum of a
   // move per slot plus the frame end. Partial frames sometimes pick a slot at or
   // beyond the slot count, or a huge or negative one, and sometimes drop the report
   // so that two frames merge.
   task automatic play_frame(input int unsigned slots, input bit full);
      int unsigned touches;
      logic [31:0] sel;
      logic [31:0] id;
      touches = full ? slots : $urandom_range(1, slots);
      for (int unsigned i = 0; i < touches; i++) begin
         if (!full && $urandom_range(0, 9) == 0) send_noise();
         if (full) sel = i;
         else if ($urandom_range(0, 9) == 0)
            sel = $urandom_range(0, 1) ? $urandom_range(slots, 31) : $urandom();
         else sel = $urandom_range(0, slots - 1);
         send_event(TYPE_ABS, CODE_SLOT, sel);
         frame_events++;
         if (full || $urandom_range(0, 2) == 0) begin
            id = $urandom();
            if (full && id == NO_CONTACT) id = '0;
            else if (!full && $urandom_range(0, 1) == 0) id = NO_CONTACT;
            send_event(TYPE_ABS, CODE_TRACK, id);
            frame_events++;
         end
         if (full || $urandom_range(0, 3) != 0) begin
            send_event(TYPE_ABS, CODE_POS_X, $urandom());
            frame_events++;
         end
         if ($urandom_range(0, 3) != 0) begin
            send_event(TYPE_ABS, CODE_POS_Y, $urandom());
            frame_events++;
         end
      end
      if (full || $urandom_range(0, 15) != 0) begin
         send_event(TYPE_SYN, CODE_REPORT, '0);
         frame_events++;
      end
   endtask

   initial begin
      logic [4:0]  settings [7];
      int unsigned live;
      int          target;

      settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd0};
      settings[6] = 5'($urandom_range(1, 31));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset slot count of ten.
      send_event(TYPE_ABS, CODE_SLOT, 32'd0);
      send_event(TYPE_ABS, CODE_TRACK, 32'h7FFF_FFFF);   // finger down, largest id
      send_event(TYPE_ABS, CODE_POS_X, 32'h7FFF_FFFF);
      send_event(TYPE_ABS, CODE_POS_Y, 32'h8000_0000);
      send_event(TYPE_SYN, CODE_REPORT, 32'd0);          // move and frame end
      send_event(TYPE_ABS, CODE_SLOT, 32'd9);            // top slot in range
      send_event(TYPE_ABS, CODE_TRACK, 32'h8000_0000);   // smallest id
      send_event(TYPE_ABS, CODE_POS_X, 32'd0);
      send_event(TYPE_SYN, CODE_REPORT, 32'd0);
      // Lift on an idle slot still reports a finger up, carrying no contact.
      send_event(TYPE_ABS, CODE_SLOT, 32'd3);
      send_event(TYPE_ABS, CODE_TRACK, NO_CONTACT);
      // A moved idle slot keeps its mark and the report emits nothing.
      send_event(TYPE_ABS, CODE_POS_Y, 32'd77);
      send_event(TYPE_SYN, CODE_REPORT, 32'd0);
      // Selected slot at the slot count, and one that is negative as signed.
      send_event(TYPE_ABS, CODE_SLOT, 32'd10);
      send_event(TYPE_ABS, CODE_TRACK, 32'd42);
      send_event(TYPE_ABS, CODE_POS_X, 32'd5);
      send_event(TYPE_ABS, CODE_SLOT, 32'hFFFF_FFFF);
      send_event(TYPE_ABS, CODE_TRACK, 32'd1);
      // Unknown type, two sync codes other than report, and an unknown axis code.
      send_event(5'd31, 10'h3FF, 32'hFFFF_FFFF);
      send_event(TYPE_SYN, 10'd2, 32'd0);
      send_event(TYPE_SYN, 10'h3FF, 32'h5555_AAAA);
      send_event(TYPE_ABS, 10'd0, 32'd123);
      // Lift the first contact: the finger up carries its old id.
      send_event(TYPE_ABS, CODE_SLOT, 32'd0);
      send_event(TYPE_ABS, CODE_TRACK, NO_CONTACT);
      send_event(TYPE_SYN, CODE_REPORT, 32'd0);

      // Random part: one phase per slot count setting, extremes first. Zero and
      // anything above sixteen are folded by the block, so the stimulus folds them
      // the same way to know which slots are live.
      target = 0;
      foreach (settings[p]) begin
         wait_idle();
         write_slot_count(settings[p]);
         live = 32'(settings[p]);
         if (live == 0) live = 32'(DEFAULT_SLOTS);
         if (live > MAX_SLOTS) live = MAX_SLOTS;
         target += EVENTS_PER_PHASE;
         play_frame(live, 1'b1);
         while (frame_events < target) play_frame(live, 1'b0);
      end

      wait_idle();
      if (error_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
